[design/fraction_reduce_gcd_macros.svh]
// Assertion macros shared by the fraction reduction block.
`ifndef FRACTION_REDUCE_GCD_MACROS_SVH
`define FRACTION_REDUCE_GCD_MACROS_SVH

`ifndef SYNTH
`define FRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define FRG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FRG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/frg_pkg.sv]
`default_nettype none

package frg_pkg;

	localparam int WIDTH = 32;
	localparam int K_W   = $clog2(WIDTH);
	localparam int CNT_W = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic scale;
		logic div_step;
		logic out_load;
	} frg_cmd_t;

	typedef struct packed {
		logic zero_den;
		logic gcd_done;
	} frg_sts_t;

	function automatic word_t magnitude(word_t v);
		return v[WIDTH-1] ? word_t'(~v + 1'b1) : v;
	endfunction

	function automatic word_t apply_sign(word_t q, logic neg);
		return neg ? word_t'(~q + 1'b1) : q;
	endfunction

endpackage

`default_nettype wire

[design/fraction_reduce_gcd.sv]
`default_nettype none

// Reduces a signed fraction to lowest terms. Each input item carries a numerator
// (s_tdata[31:0]) and a denominator (s_tdata[63:32]), both two's complement; the
// result item gives each part divided exactly by the gcd of the magnitudes, each
// keeping its own sign (the denominator sign is not normalised). A zero numerator
// gives 0 over +1 or -1; a zero denominator sets m_tuser and returns zeros. One
// item is processed at a time: a load step, then the binary gcd loop of one
// shift or subtract per cycle (data dependent) and a check that sees it finish,
// a step to scale the gcd, a restoring division of WIDTH quotient bits
// (both parts side by side) and a register for the result, which waits until
// the output register is free.
// A zero denominator skips the gcd and division. The next item is accepted as
// soon as the result sits in the output register.
module fraction_reduce_gcd (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// numerator, denominator
	input  wire logic [2*frg_pkg::WIDTH-1:0] s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// reduced_numerator, reduced_denominator
	output logic      [2*frg_pkg::WIDTH-1:0] m_tdata,
	// zero_denominator
	output logic                             m_tuser
);
	import frg_pkg::*;

	frg_cmd_t cmd;
	frg_sts_t sts;

	frg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	frg_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.out_data (m_tdata),
		.out_flag (m_tuser)
	);

endmodule

`default_nettype wire

[design/frg_datapath.sv]
`default_nettype none

module frg_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire frg_pkg::frg_cmd_t        cmd,
	output frg_pkg::frg_sts_t             sts,
	input  wire logic [2*frg_pkg::WIDTH-1:0] in_data,
	output logic      [2*frg_pkg::WIDTH-1:0] out_data,
	output logic                          out_flag
);
	import frg_pkg::*;

	word_t           a_q, b_q, g_q;
	logic [K_W-1:0]  k_q;
	word_t           n_mag_q, d_mag_q;
	logic            n_neg_q, d_neg_q, zden_q;
	word_t           quo_n_q, quo_d_q, rem_n_q, rem_d_q;
	word_t           res_n_q, res_d_q;
	logic            res_z_q;

	word_t           num_in, den_in;
	logic [WIDTH:0]  sh_n, sh_d;
	logic            ge_n, ge_d;

	assign num_in = in_data[WIDTH-1:0];
	assign den_in = in_data[2*WIDTH-1:WIDTH];

	assign sts.zero_den = zden_q;
	assign sts.gcd_done = (a_q == '0);

	assign sh_n = {rem_n_q, quo_n_q[WIDTH-1]};
	assign sh_d = {rem_d_q, quo_d_q[WIDTH-1]};
	assign ge_n = (sh_n >= {1'b0, g_q});
	assign ge_d = (sh_d >= {1'b0, g_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_mag_q <= magnitude(num_in);
			d_mag_q <= magnitude(den_in);
			a_q     <= magnitude(num_in);
			b_q     <= magnitude(den_in);
			k_q     <= '0;
			n_neg_q <= num_in[WIDTH-1];
			d_neg_q <= den_in[WIDTH-1];
			zden_q  <= (den_in == '0);
		end else if (cmd.gcd_step) begin
			// binary gcd: strip common twos, then halve or subtract
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= word_t'(a_q - b_q) >> 1;
			end else begin
				b_q <= word_t'(b_q - a_q) >> 1;
			end
		end

		if (cmd.scale) begin
			g_q     <= word_t'(b_q << k_q);
			rem_n_q <= '0;
			rem_d_q <= '0;
			quo_n_q <= n_mag_q;
			quo_d_q <= d_mag_q;
		end else if (cmd.div_step) begin
			rem_n_q <= ge_n ? word_t'(sh_n - {1'b0, g_q}) : sh_n[WIDTH-1:0];
			rem_d_q <= ge_d ? word_t'(sh_d - {1'b0, g_q}) : sh_d[WIDTH-1:0];
			quo_n_q <= {quo_n_q[WIDTH-2:0], ge_n};
			quo_d_q <= {quo_d_q[WIDTH-2:0], ge_d};
		end

		if (cmd.out_load) begin
			res_n_q <= zden_q ? '0 : apply_sign(quo_n_q, n_neg_q);
			res_d_q <= zden_q ? '0 : apply_sign(quo_d_q, d_neg_q);
			res_z_q <= zden_q;
		end
	end

	assign out_data = {res_d_q, res_n_q};
	assign out_flag = res_z_q;

`include "fraction_reduce_gcd_macros.svh"

	`FRG_ASSERT_IMP(a_gcd_b_nonzero, clk, arst_n, cmd.gcd_step, b_q != '0, "gcd step with b zero")
	`FRG_ASSERT_IMP(a_div_g_nonzero, clk, arst_n, cmd.div_step, g_q != '0, "divide by zero gcd")
	`FRG_ASSERT_IMP(a_exact_div, clk, arst_n, cmd.out_load && !zden_q,
		rem_n_q == '0 && rem_d_q == '0, "division by gcd not exact")

endmodule

`default_nettype wire

[design/frg_ctrl.sv]
`default_nettype none

module frg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output frg_pkg::frg_cmd_t      cmd,
	input  wire frg_pkg::frg_sts_t sts
);
	import frg_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.zero_den) begin
					state_d = ST_DONE;
				end else if (sts.gcd_done) begin
					state_d = ST_SCALE;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				cnt_d     = CNT_W'(WIDTH - 1);
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire
